FILE: design/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
// Holds the decoder state, the per-result record and the result codes.
// No dependencies.
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int MAX_RES = 5;   // up to four UTF-8 bytes and a trailing error

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_BSL  = 3'd4,
        PH_U    = 3'd5,
        PH_HEX2 = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERR   = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE        = 4'd0,
        ERR_NO_QUOTE    = 4'd1,
        ERR_CTRL        = 4'd2,
        ERR_BAD_ESC     = 4'd3,
        ERR_BAD_HEX     = 4'd4,
        ERR_LONE_HIGH   = 4'd5,
        ERR_BAD_LOW     = 4'd6,
        ERR_LONE_LOW    = 4'd7,
        ERR_UNTERM      = 4'd8,
        ERR_TRUNC_ESC   = 4'd9,
        ERR_TRUNC_UNI   = 4'd10
    } t_err;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] hex_accum;
        logic [1:0]  hex_count;
        logic [9:0]  high_half;
    } t_state;

    localparam t_state STATE_IDLE = '{phase: PH_IDLE, hex_accum: '0,
                                      hex_count: '0, high_half: '0};

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        t_err        err;
        logic        last;
    } t_result;

endpackage

FILE: design/jsu_step.sv
// Next-state and result logic for one input byte of a JSON string literal.
// Decodes escapes, joins surrogate pairs and encodes UTF-8.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_step
    import jsu_pkg::*;
(
    input  t_state                  i_state,
    input  logic [7:0]              i_byte,
    input  logic                    i_last,
    output t_state                  o_state,
    output t_result [MAX_RES-1:0]   o_res,
    output logic [2:0]              o_count
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } t_utf8;

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = '0;
        if (c inside {[8'h30:8'h39]}) begin
            v = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            v = {1'b1, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    function automatic t_utf8 utf8_enc(input logic [20:0] cp);
        t_utf8 u;
        u = '0;
        if (cp <= 21'h7F) begin
            u.len      = 3'd1;
            u.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            u.len      = 3'd2;
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            u.len      = 3'd3;
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            u.len      = 3'd4;
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

    logic [4:0]  hex;
    logic [15:0] acc_n;
    logic [10:0] plane;
    logic [20:0] cp;
    t_utf8       enc;

    assign hex   = hex_val(i_byte);
    assign acc_n = {i_state.hex_accum[11:0], hex[3:0]};
    // pair: 0x10000 + (high << 10) + low[9:0]
    assign plane = {1'b0, i_state.high_half} + 11'd64;
    assign cp    = (i_state.phase == PH_HEX2) ? {plane, acc_n[9:0]} : {5'b0, acc_n};
    assign enc   = utf8_enc(cp);

    t_state                 ns;
    t_err                   err;
    logic                   close;
    logic                   emit_body;
    logic [7:0]             body_val;
    logic                   emit_cp;
    logic [2:0]             nd;
    logic [2:0]             cnt;
    logic                   tail;
    logic [MAX_RES-1:0][7:0] dbytes;
    t_result [MAX_RES-1:0]  res;

    always_comb begin
        ns        = i_state;
        err       = ERR_NONE;
        close     = 1'b0;
        emit_body = 1'b0;
        body_val  = i_byte;
        emit_cp   = 1'b0;

        case (i_state.phase)
            PH_BODY: begin
                if (i_byte == CH_QUOTE) begin
                    close = 1'b1;
                end else if (i_byte < CH_SPACE) begin
                    err = ERR_CTRL;
                end else if (i_byte == CH_BSL) begin
                    if (i_last) begin
                        err = ERR_TRUNC_ESC;
                    end else begin
                        ns.phase = PH_ESC;
                    end
                end else begin
                    emit_body = 1'b1;
                end
            end
            PH_ESC: begin
                case (i_byte)
                    CH_QUOTE, CH_BSL, CH_SLASH: emit_body = 1'b1;
                    CH_B: begin
                        emit_body = 1'b1;
                        body_val  = 8'h08;
                    end
                    CH_F: begin
                        emit_body = 1'b1;
                        body_val  = 8'h0C;
                    end
                    CH_N: begin
                        emit_body = 1'b1;
                        body_val  = 8'h0A;
                    end
                    CH_R: begin
                        emit_body = 1'b1;
                        body_val  = 8'h0D;
                    end
                    CH_T: begin
                        emit_body = 1'b1;
                        body_val  = 8'h09;
                    end
                    CH_U: begin
                        if (i_last) begin
                            err = ERR_TRUNC_UNI;
                        end else begin
                            ns.phase     = PH_HEX1;
                            ns.hex_accum = '0;
                            ns.hex_count = '0;
                        end
                    end
                    default: err = ERR_BAD_ESC;
                endcase
            end
            PH_HEX1, PH_HEX2: begin
                if (!hex[4]) begin
                    err = ERR_BAD_HEX;
                end else if (i_state.hex_count != 2'd3) begin
                    if (i_last) begin
                        err = ERR_TRUNC_UNI;
                    end else begin
                        ns.hex_accum = acc_n;
                        ns.hex_count = i_state.hex_count + 2'd1;
                    end
                end else if (i_state.phase == PH_HEX1) begin
                    if (acc_n inside {[16'hD800:16'hDBFF]}) begin
                        if (i_last) begin
                            err = ERR_LONE_HIGH;
                        end else begin
                            ns.phase     = PH_BSL;
                            ns.high_half = acc_n[9:0];
                            ns.hex_accum = '0;
                            ns.hex_count = '0;
                        end
                    end else if (acc_n inside {[16'hDC00:16'hDFFF]}) begin
                        err = ERR_LONE_LOW;
                    end else begin
                        emit_cp = 1'b1;
                    end
                end else begin
                    if (acc_n inside {[16'hDC00:16'hDFFF]}) begin
                        emit_cp = 1'b1;
                    end else begin
                        err = ERR_BAD_LOW;
                    end
                end
            end
            PH_BSL: begin
                if (i_byte != CH_BSL || i_last) begin
                    err = ERR_LONE_HIGH;
                end else begin
                    ns.phase = PH_U;
                end
            end
            PH_U: begin
                if (i_byte != CH_U) begin
                    err = ERR_LONE_HIGH;
                end else if (i_last) begin
                    err = ERR_TRUNC_UNI;
                end else begin
                    ns.phase     = PH_HEX2;
                    ns.hex_accum = '0;
                    ns.hex_count = '0;
                end
            end
            default: begin
                // idle and the unused code
                ns = STATE_IDLE;
                if (i_byte != CH_QUOTE) begin
                    err = ERR_NO_QUOTE;
                end else if (i_last) begin
                    err = ERR_UNTERM;
                end else begin
                    ns.phase = PH_BODY;
                end
            end
        endcase

        nd     = '0;
        dbytes = '0;
        if (emit_body) begin
            nd        = 3'd1;
            dbytes[0] = body_val;
            ns.phase  = PH_BODY;
        end
        if (emit_cp) begin
            nd          = enc.len;
            dbytes[3:0] = enc.bytes;
            ns          = STATE_IDLE;
            ns.phase    = PH_BODY;
        end
        // data on the final byte leaves the string open
        if ((emit_body || emit_cp) && i_last) begin
            err = ERR_UNTERM;
        end
        if (close || err != ERR_NONE) begin
            ns = STATE_IDLE;
        end

        tail = close || (err != ERR_NONE);
        cnt  = nd + {2'b0, tail};
        for (int i = 0; i < MAX_RES; i++) begin
            res[i] = '{kind: KIND_DATA, data: 8'h00, err: ERR_NONE, last: 1'b0};
            if (3'(i) < nd) begin
                res[i].data = dbytes[i];
            end else if (3'(i) == nd && tail) begin
                res[i].kind = close ? KIND_CLOSE : KIND_ERR;
                res[i].err  = err;
            end
            res[i].last = (cnt != 3'd0) && (3'(i) == cnt - 3'd1);
        end
    end

    assign o_state = ns;
    assign o_res   = res;
    assign o_count = cnt;

endmodule

FILE: design/json_string_unescape_utf8.sv
// JSON string literal unescaper: takes the text one byte per transaction starting at the
// opening quote and emits the decoded string as UTF-8 bytes, a close marker at the closing
// quote, or an error code, after which it waits for the next opening quote. A byte that
// yields zero or one result is taken every cycle while the output is ready; one that yields
// k results (k up to 5, e.g. a \uXXXX escape giving a 3- or 4-byte UTF-8 character) holds
// the input until the result buffer, draining one result per cycle while the output is
// ready, is at its last entry. The results are registered. Depends on jsu_pkg and jsu_step.
`timescale 1ns / 1ps

module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic        i_s_axis_tlast,   // in_last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] out_byte, [11:8] err_code, [15:12] zero
    output logic [1:0]  o_m_axis_tuser,   // [1:0] out_kind
    output logic        o_m_axis_tlast    // out_last
);

    t_state                r_state;
    t_result [MAX_RES-1:0] r_buf;
    logic [2:0]            r_cnt;

    t_state                n_state;
    t_result [MAX_RES-1:0] n_res;
    logic [2:0]            n_cnt;

    logic accept;
    logic pop;

    jsu_step u_step (
        .i_state (r_state),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_state (n_state),
        .o_res   (n_res),
        .o_count (n_cnt)
    );

    // take a new byte when the buffer is empty or its final entry leaves now
    assign o_s_axis_tready = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign pop             = (r_cnt != 3'd0) && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_IDLE;
            r_cnt   <= '0;
        end else if (accept) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end else if (pop) begin
            r_cnt   <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf <= n_res;
        end else if (pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

    assign o_m_axis_tvalid = (r_cnt != 3'd0);
    assign o_m_axis_tdata  = {4'b0, r_buf[0].err, r_buf[0].data};
    assign o_m_axis_tuser  = r_buf[0].kind;
    assign o_m_axis_tlast  = r_buf[0].last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(MAX_RES))
        else $error("result count out of range");

    a_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> r_cnt == 3'd1)
        else $error("tlast not on final buffered result");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_ERR |-> o_m_axis_tdata[11:8] != ERR_NONE)
        else $error("error result without code");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != KIND_DATA |-> r_state.phase == PH_IDLE)
        else $error("decoder not idle after close or error");

endmodule
